/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the jump-step transposition block.
// Needs clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge out of reset.
`define JSBT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("jsbt assertion failed");

// Check that cons holds in the same cycle as ante.
`define JSBT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsbt implication failed");

`endif

/* rtl/jsbt_pkg.sv */
// Package of the jump-step transposition block: widths, codes, state and struct types.
// Depends on nothing; the interfaces, the unit and the remainder unit refer to it by scoped names.
`timescale 1ns / 1ps

package jsbt_pkg;

  localparam int BUF_DEPTH  = 512;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 5;
  localparam int LEN_W      = 9;
  localparam int MOD_W      = LEN_W + 1;
  localparam int MOD_CNT_W  = $clog2(MOD_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;
  localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;

  localparam logic [STEP_W-1:0] STEP_RST = 5'd3;
  localparam logic [LEN_W-1:0]  LEN_RST  = 9'd11;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_TRUNC   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP  = 2'd0,
    CFG_LEN   = 2'd1,
    CFG_START = 2'd2,
    CFG_MODE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MODWAIT,
    ST_ACCESS,
    ST_MARK,
    ST_DREAD,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LEN_W-1:0] rem;
  } mod_rsp_t;

endpackage

/* rtl/jsbt_if.sv */
// Stream interfaces of the jump-step transposition block: input items and results.
// Depends on jsbt_pkg for the field widths and the status type.
`timescale 1ns / 1ps

interface jsbt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [jsbt_pkg::BYTE_W-1:0] data_byte;
  logic                      stream_end;

  modport source (output valid, opcode, data_byte, stream_end, input ready);
  modport sink   (input valid, opcode, data_byte, stream_end, output ready);
endinterface

interface jsbt_out_if;
  logic                        valid;
  logic                        ready;
  jsbt_pkg::status_t           status;
  logic [jsbt_pkg::BYTE_W-1:0] out_byte;
  logic                        out_valid;
  logic                        end_of_block;

  modport source (output valid, status, out_byte, out_valid, end_of_block, input ready);
  modport sink   (input valid, status, out_byte, out_valid, end_of_block, output ready);
endinterface

/* rtl/jump_step_block_transposition_unit.sv */
// Jump-step block transposition unit: control sequencer, configuration and result register.
// Depends on jsbt_pkg, jsbt_if, jsbt_ram, jsbt_mod_unit and assert_macros.svh.
//
// Use: items arrive on in_ch (valid/ready); each is a load of one byte or a fetch of one
// output byte and gives exactly one result on out_ch (valid/ready). The user must write
// registers via cfg_we/cfg_index/cfg_wdata only while the block is idle; not enforced.
// Throughput: one item at a time. A refused load, an empty fetch or a plain encode load
// goes straight to the result stage; a short-block encode load first writes the marker
// and a decode fetch first reads the buffer. An encode fetch or a decode load reduces
// the jump position, makes its buffer access, steps, reduces again and commits, with a
// run of the bit-serial remainder unit for each reduction of the jump position that falls
// outside the fast path (a stale position, or a step that carries it past the block end).
// The block is ready for the next item once the result enters the output register. The
// steps follow from the buffer: one access per cycle, with registered read data.
// Reset: after rst_n the block sweeps the 512-entry buffer, writing 0x20 one entry per
// cycle; in_ch.ready stays low until the sweep ends. Configuration writes are taken
// at any time. Counters clear, registers return to step 3, length 11, start 0, encode.
// Stall: a result waits in the output register while out_ch.ready is low; the block
// may take and work on the next item meanwhile, holding its result until the slot frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jump_step_block_transposition_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  jsbt_in_if.sink                          in_ch,
  jsbt_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [jsbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jsbt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic [jsbt_pkg::STEP_W-1:0] step_key_r;
  logic [jsbt_pkg::LEN_W-1:0]  block_len_r;
  logic [jsbt_pkg::LEN_W-1:0]  start_offset_r;
  logic                        decode_mode_r;

  // Control state
  jsbt_pkg::state_t            state_r, state_nxt;
  logic                        pos_next_r, pos_next_nxt;
  logic [jsbt_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [jsbt_pkg::LEN_W-1:0]  load_count_r, load_count_nxt;
  logic [jsbt_pkg::LEN_W-1:0]  jump_pos_r, jump_pos_nxt;
  logic [jsbt_pkg::LEN_W-1:0]  drain_count_r, drain_count_nxt;
  logic                        pending_r, pending_nxt;
  logic                        out_vld_r, out_vld_nxt;

  // Item and result payload
  logic                        op_r, op_nxt;
  logic [jsbt_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic                        last_r, last_nxt;
  logic [jsbt_pkg::MOD_W-1:0]  pos_r, pos_nxt;
  jsbt_pkg::status_t           res_status_r, res_status_nxt;
  logic [jsbt_pkg::BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic                        res_ov_r, res_ov_nxt;
  logic                        res_eob_r, res_eob_nxt;
  jsbt_pkg::status_t           out_status_r, out_status_nxt;
  logic [jsbt_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_ov_r, out_ov_nxt;
  logic                        out_eob_r, out_eob_nxt;

  // Derived values
  logic [jsbt_pkg::LEN_W-1:0]  n_eff;
  logic [jsbt_pkg::LEN_W-1:0]  start_eff;
  logic [jsbt_pkg::MOD_W-1:0]  n_wide;
  logic [jsbt_pkg::MOD_W-1:0]  lc_inc;
  logic [jsbt_pkg::MOD_W-1:0]  dc_inc;
  logic                        pos_in_range;
  logic                        in_xfer;
  logic                        out_free;

  // Buffer and remainder unit
  logic                        mem_we;
  logic [jsbt_pkg::ADDR_W-1:0] mem_waddr;
  logic [jsbt_pkg::BYTE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [jsbt_pkg::ADDR_W-1:0] mem_raddr;
  logic [jsbt_pkg::BYTE_W-1:0] mem_rdata;
  logic                        mod_start;
  jsbt_pkg::mod_rsp_t          mod_rsp;

  jsbt_ram #(
    .DEPTH (jsbt_pkg::BUF_DEPTH),
    .WIDTH (jsbt_pkg::BYTE_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  jsbt_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (pos_r),
    .divisor  (n_eff),
    .rsp      (mod_rsp)
  );

  // Effective block length: zero acts as one, clamp to the buffer depth.
  always_comb begin
    n_eff = block_len_r;
    if (block_len_r == '0) begin
      n_eff = jsbt_pkg::LEN_W'(1);
    end
    if (32'(block_len_r) > jsbt_pkg::BUF_DEPTH) begin
      n_eff = jsbt_pkg::LEN_W'(jsbt_pkg::BUF_DEPTH);
    end
  end

  assign start_eff    = (start_offset_r >= n_eff) ? '0 : start_offset_r;
  assign n_wide       = {1'b0, n_eff};
  assign lc_inc       = {1'b0, load_count_r} + jsbt_pkg::MOD_W'(1);
  assign dc_inc       = {1'b0, drain_count_r} + jsbt_pkg::MOD_W'(1);
  assign pos_in_range = (pos_r < n_wide);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_vld_r || out_ch.ready;

  assign in_ch.ready         = (state_r == jsbt_pkg::ST_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.out_valid    = out_ov_r;
  assign out_ch.end_of_block = out_eob_r;

  // Sequencer: next state, buffer accesses and result staging.
  always_comb begin
    state_nxt       = state_r;
    pos_next_nxt    = pos_next_r;
    clr_cnt_nxt     = clr_cnt_r;
    load_count_nxt  = load_count_r;
    jump_pos_nxt    = jump_pos_r;
    drain_count_nxt = drain_count_r;
    pending_nxt     = pending_r;
    op_nxt          = op_r;
    data_nxt        = data_r;
    last_nxt        = last_r;
    pos_nxt         = pos_r;
    res_status_nxt  = res_status_r;
    res_byte_nxt    = res_byte_r;
    res_ov_nxt      = res_ov_r;
    res_eob_nxt     = res_eob_r;
    out_vld_nxt     = out_vld_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_byte_nxt    = out_byte_r;
    out_ov_nxt      = out_ov_r;
    out_eob_nxt     = out_eob_r;
    mem_we          = 1'b0;
    mem_waddr       = jsbt_pkg::ADDR_W'(load_count_r);
    mem_wdata       = data_r;
    mem_re          = 1'b0;
    mem_raddr       = jsbt_pkg::ADDR_W'(drain_count_r);
    mod_start       = 1'b0;

    unique case (state_r)
      jsbt_pkg::ST_CLEAR: begin
        // Sweep the buffer with the fill byte, one entry a cycle.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = jsbt_pkg::FILL_BYTE;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == jsbt_pkg::ADDR_W'(jsbt_pkg::BUF_DEPTH - 1)) begin
          state_nxt = jsbt_pkg::ST_IDLE;
        end
      end

      jsbt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_ch.opcode;
          data_nxt       = in_ch.data_byte;
          last_nxt       = in_ch.stream_end;
          res_status_nxt = jsbt_pkg::STAT_OK;
          res_byte_nxt   = '0;
          res_ov_nxt     = 1'b0;
          res_eob_nxt    = 1'b0;
          pos_next_nxt   = 1'b0;
          state_nxt      = jsbt_pkg::ST_EMIT;
          if (in_ch.opcode == jsbt_pkg::OP_LOAD) begin
            if (pending_r) begin
              res_status_nxt = jsbt_pkg::STAT_REFUSED;
            end else if (!decode_mode_r) begin
              // Encode load: store in order, close the block when full or at stream end.
              if (32'(load_count_r) < jsbt_pkg::BUF_DEPTH) begin
                mem_we    = 1'b1;
                mem_waddr = jsbt_pkg::ADDR_W'(load_count_r);
                mem_wdata = in_ch.data_byte;
              end
              load_count_nxt = jsbt_pkg::LEN_W'(lc_inc);
              if (lc_inc >= n_wide || in_ch.stream_end) begin
                pending_nxt     = 1'b1;
                jump_pos_nxt    = start_eff;
                drain_count_nxt = '0;
                // Short block: place the marker right after the last byte.
                if (lc_inc < n_wide && 32'(lc_inc) < jsbt_pkg::BUF_DEPTH) begin
                  state_nxt = jsbt_pkg::ST_MARK;
                end
              end
            end else begin
              // Decode load: scatter to the jump position, reduced first.
              pos_nxt   = (load_count_r == '0) ? {1'b0, start_eff} : {1'b0, jump_pos_r};
              state_nxt = jsbt_pkg::ST_REDUCE;
            end
          end else begin
            if (!pending_r) begin
              res_status_nxt = jsbt_pkg::STAT_EMPTY;
            end else if (!decode_mode_r) begin
              pos_nxt   = {1'b0, jump_pos_r};
              state_nxt = jsbt_pkg::ST_REDUCE;
            end else if (drain_count_r < n_eff) begin
              mem_re    = 1'b1;
              mem_raddr = jsbt_pkg::ADDR_W'(drain_count_r);
              state_nxt = jsbt_pkg::ST_DREAD;
            end else begin
              // Drained past the block end: reads as zero, so the block ends here.
              res_eob_nxt     = 1'b1;
              pending_nxt     = 1'b0;
              load_count_nxt  = '0;
              drain_count_nxt = '0;
            end
          end
        end
      end

      jsbt_pkg::ST_REDUCE: begin
        if (pos_in_range) begin
          state_nxt = pos_next_r ? jsbt_pkg::ST_COMMIT : jsbt_pkg::ST_ACCESS;
        end else begin
          mod_start = 1'b1;
          state_nxt = jsbt_pkg::ST_MODWAIT;
        end
      end

      jsbt_pkg::ST_MODWAIT: begin
        if (mod_rsp.done) begin
          pos_nxt   = {1'b0, mod_rsp.rem};
          state_nxt = pos_next_r ? jsbt_pkg::ST_COMMIT : jsbt_pkg::ST_ACCESS;
        end
      end

      jsbt_pkg::ST_ACCESS: begin
        // Position is in range: one buffer access, then advance by the step.
        if (op_r == jsbt_pkg::OP_FETCH) begin
          mem_re    = 1'b1;
          mem_raddr = jsbt_pkg::ADDR_W'(pos_r);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = jsbt_pkg::ADDR_W'(pos_r);
          mem_wdata = (data_r == jsbt_pkg::MARK_BYTE) ? '0 : data_r;
        end
        pos_nxt      = pos_r + jsbt_pkg::MOD_W'(step_key_r);
        pos_next_nxt = 1'b1;
        state_nxt    = jsbt_pkg::ST_REDUCE;
      end

      jsbt_pkg::ST_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = jsbt_pkg::ADDR_W'(load_count_r);
        mem_wdata = jsbt_pkg::MARK_BYTE;
        state_nxt = jsbt_pkg::ST_EMIT;
      end

      jsbt_pkg::ST_DREAD: begin
        if (mem_rdata == '0) begin
          res_eob_nxt = 1'b1;
        end else begin
          res_byte_nxt    = mem_rdata;
          res_ov_nxt      = 1'b1;
          drain_count_nxt = jsbt_pkg::LEN_W'(dc_inc);
          res_eob_nxt     = (dc_inc >= n_wide);
        end
        if (mem_rdata == '0 || dc_inc >= n_wide) begin
          pending_nxt     = 1'b0;
          load_count_nxt  = '0;
          drain_count_nxt = '0;
        end
        state_nxt = jsbt_pkg::ST_EMIT;
      end

      jsbt_pkg::ST_COMMIT: begin
        jump_pos_nxt = jsbt_pkg::LEN_W'(pos_r);
        if (op_r == jsbt_pkg::OP_FETCH) begin
          // Encode drain: the byte read in the access state is held in the read register.
          res_byte_nxt = mem_rdata;
          res_ov_nxt   = 1'b1;
          if (dc_inc >= n_wide) begin
            res_eob_nxt     = 1'b1;
            pending_nxt     = 1'b0;
            load_count_nxt  = '0;
            drain_count_nxt = '0;
          end else begin
            drain_count_nxt = jsbt_pkg::LEN_W'(dc_inc);
          end
        end else begin
          if (lc_inc >= n_wide) begin
            load_count_nxt  = jsbt_pkg::LEN_W'(lc_inc);
            pending_nxt     = 1'b1;
            drain_count_nxt = '0;
          end else if (last_r) begin
            // Stream ended mid-block: drop the partial block.
            res_status_nxt = jsbt_pkg::STAT_TRUNC;
            load_count_nxt = '0;
          end else begin
            load_count_nxt = jsbt_pkg::LEN_W'(lc_inc);
          end
        end
        state_nxt = jsbt_pkg::ST_EMIT;
      end

      jsbt_pkg::ST_EMIT: begin
        // Hold the result until the output slot frees.
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_byte_nxt   = res_byte_r;
          out_ov_nxt     = res_ov_r;
          out_eob_nxt    = res_eob_r;
          state_nxt      = jsbt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = jsbt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= jsbt_pkg::ST_CLEAR;
      pos_next_r    <= 1'b0;
      clr_cnt_r     <= '0;
      load_count_r  <= '0;
      jump_pos_r    <= '0;
      drain_count_r <= '0;
      pending_r     <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_next_r    <= pos_next_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      load_count_r  <= load_count_nxt;
      jump_pos_r    <= jump_pos_nxt;
      drain_count_r <= drain_count_nxt;
      pending_r     <= pending_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // Configuration registers: written by index, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_key_r     <= jsbt_pkg::STEP_RST;
      block_len_r    <= jsbt_pkg::LEN_RST;
      start_offset_r <= '0;
      decode_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (jsbt_pkg::cfg_idx_t'(cfg_index))
        jsbt_pkg::CFG_STEP:  step_key_r     <= cfg_wdata[jsbt_pkg::STEP_W-1:0];
        jsbt_pkg::CFG_LEN:   block_len_r    <= cfg_wdata[jsbt_pkg::LEN_W-1:0];
        jsbt_pkg::CFG_START: start_offset_r <= cfg_wdata[jsbt_pkg::LEN_W-1:0];
        jsbt_pkg::CFG_MODE:  decode_mode_r  <= cfg_wdata[0];
        default:             decode_mode_r  <= decode_mode_r;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    data_r       <= data_nxt;
    last_r       <= last_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_byte_r   <= res_byte_nxt;
    res_ov_r     <= res_ov_nxt;
    res_eob_r    <= res_eob_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_ov_r     <= out_ov_nxt;
    out_eob_r    <= out_eob_nxt;
  end

  // The buffer is never read and written in one cycle.
  `JSBT_ASSERT_ALWAYS(a_one_access, !(mem_we && mem_re))
  // A buffer access by jump position only ever sees a reduced position.
  `JSBT_ASSERT_IMPL(a_pos_reduced, state_r == jsbt_pkg::ST_ACCESS, pos_r < n_wide)
  // The remainder unit is only started when it is free.
  `JSBT_ASSERT_IMPL(a_mod_free, mod_start, !mod_rsp.busy)
  // A block only becomes pending through a load.
  `JSBT_ASSERT_IMPL(a_pending_by_load, $rose(pending_r), op_r == jsbt_pkg::OP_LOAD)

endmodule

/* rtl/jsbt_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module jsbt_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/jsbt_mod_unit.sv */
// Bit-serial remainder unit: one restoring step per cycle over MOD_W dividend bits.
// Depends on jsbt_pkg for widths and the response struct.
`timescale 1ns / 1ps

module jsbt_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [jsbt_pkg::MOD_W-1:0]   dividend,
  input  logic [jsbt_pkg::LEN_W-1:0]   divisor,
  output jsbt_pkg::mod_rsp_t           rsp
);

  logic [jsbt_pkg::MOD_CNT_W-1:0] cnt_r;
  logic                           done_r;
  logic [jsbt_pkg::MOD_W-1:0]     dvd_r;
  logic [jsbt_pkg::LEN_W-1:0]     dsr_r;
  logic [jsbt_pkg::LEN_W-1:0]     rem_r;
  logic [jsbt_pkg::LEN_W-1:0]     rem_nxt;
  logic [jsbt_pkg::MOD_W-1:0]     trial;

  // Shift in the next dividend bit, subtract when the trial reaches the divisor.
  always_comb begin
    trial = {rem_r, dvd_r[jsbt_pkg::MOD_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = jsbt_pkg::LEN_W'(trial - {1'b0, dsr_r});
    end else begin
      rem_nxt = jsbt_pkg::LEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= jsbt_pkg::MOD_CNT_W'(jsbt_pkg::MOD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == jsbt_pkg::MOD_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[jsbt_pkg::MOD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
